FILE: sv/k2h_pkg.sv
// ============================================================================
// k2h_pkg: shared types, constants and conversion functions
// Holds the code-unit constants, the halfwidth kana tables and the per-unit
// conversion functions used by the kana conversion pipeline.
// ============================================================================
`default_nettype none

package k2h_pkg;

    localparam int UNIT_W = 16;

    // Distinguished code units and ranges.
    localparam logic [7:0]  KATA_HI     = 8'h30;
    localparam logic [7:0]  HALF_HI     = 8'hFF;
    localparam logic [7:0]  HIRA_HI     = 8'h30;
    localparam logic [7:0]  KATA_LB_LO  = 8'hA0;
    localparam logic [7:0]  KATA_CV_LO  = 8'hA1;
    localparam logic [7:0]  KATA_CV_HI  = 8'hEF;
    localparam logic [7:0]  KATA_WO     = 8'hF2;
    localparam logic [7:0]  KATA_N      = 8'hF3;
    localparam logic [7:0]  KATA_SHIFT  = 8'h60;
    localparam logic [7:0]  HALF_LB_HI  = 8'hEF;
    localparam logic [7:0]  HALF_KANA_LO = 8'h66;
    localparam logic [7:0]  HALF_KANA_HI = 8'h9D;
    localparam logic [7:0]  KA_ROW_LO   = 8'h76;
    localparam logic [7:0]  KA_ROW_HI   = 8'h84;
    localparam logic [7:0]  HA_ROW_LO   = 8'h8A;
    localparam logic [7:0]  HA_ROW_HI   = 8'h8E;
    localparam logic [UNIT_W-1:0] MARK_VOICED = 16'hFF9E;
    localparam logic [UNIT_W-1:0] MARK_SEMI   = 16'hFF9F;

    // Result queue sizing.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Low byte of the hiragana for U+FF66..U+FF9D.
    localparam logic [7:0] PLAIN_MAP [0:55] = '{
        8'h92, 8'h41, 8'h43, 8'h45, 8'h47, 8'h49, 8'h83, 8'h85, 8'h87, 8'h63,
        8'hFC, 8'h42, 8'h44, 8'h46, 8'h48, 8'h4A, 8'h4B, 8'h4D, 8'h4F, 8'h51,
        8'h53, 8'h55, 8'h57, 8'h59, 8'h5B, 8'h5D, 8'h5F, 8'h61, 8'h64, 8'h66,
        8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h72, 8'h75, 8'h78,
        8'h7B, 8'h7E, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h84, 8'h86, 8'h88, 8'h89,
        8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8F, 8'h93};

    // Voiced forms: ka..to rows first, then the ha row.
    localparam logic [7:0] VOICED_MAP [0:19] = '{
        8'h4C, 8'h4E, 8'h50, 8'h52, 8'h54, 8'h56, 8'h58, 8'h5A, 8'h5C, 8'h5E,
        8'h60, 8'h62, 8'h65, 8'h67, 8'h69, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7C};

    // Semi-voiced forms of the ha row.
    localparam logic [7:0] SEMI_MAP [0:4] = '{8'h71, 8'h74, 8'h77, 8'h7A, 8'h7D};

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
    } t_result;

    // Up to two results produced by one processed code unit, in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic is_ha_row(input logic [7:0] lb);
        return (lb >= HA_ROW_LO) && (lb <= HA_ROW_HI);
    endfunction

    function automatic logic is_candidate(input logic [UNIT_W-1:0] u);
        return (u[15:8] == HALF_HI) &&
               (((u[7:0] >= KA_ROW_LO) && (u[7:0] <= KA_ROW_HI)) || is_ha_row(u[7:0]));
    endfunction

    function automatic logic [UNIT_W-1:0] convert_single(input logic [UNIT_W-1:0] u);
        logic [7:0] lb;
        logic [7:0] idx;
        lb  = u[7:0];
        idx = lb - HALF_KANA_LO;
        if ((u[15:8] == KATA_HI) && (lb >= KATA_LB_LO)) begin
            if (((lb >= KATA_CV_LO) && (lb <= KATA_CV_HI)) || (lb == KATA_WO) ||
                (lb == KATA_N)) begin
                return {HIRA_HI, lb - KATA_SHIFT};
            end
            return u;
        end
        if ((u[15:8] == HALF_HI) && (lb <= HALF_LB_HI)) begin
            if ((lb >= HALF_KANA_LO) && (lb <= HALF_KANA_HI)) begin
                return {HIRA_HI, PLAIN_MAP[idx[5:0]]};
            end
            return u;
        end
        return u;
    endfunction

    function automatic logic [UNIT_W-1:0] voiced_of(input logic [7:0] lb);
        logic [7:0] ka_off;
        logic [7:0] ha_off;
        logic [4:0] idx;
        ka_off = lb - KA_ROW_LO;
        ha_off = lb - HA_ROW_LO;
        if ((lb >= KA_ROW_LO) && (lb <= KA_ROW_HI)) begin
            idx = ka_off[4:0];
        end else begin
            idx = 5'd15 + {2'b00, ha_off[2:0]};
        end
        return {HIRA_HI, VOICED_MAP[idx]};
    endfunction

    function automatic logic [UNIT_W-1:0] semi_of(input logic [7:0] lb);
        logic [7:0] off;
        off = lb - HA_ROW_LO;
        return {HIRA_HI, SEMI_MAP[off[2:0]]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/k2h_if.sv
// ============================================================================
// k2h_if: stream channel interfaces
// Valid/ready channels for source code units and for converted result units.
// ============================================================================
`default_nettype none

interface k2h_in_if import k2h_pkg::*;;
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface k2h_out_if import k2h_pkg::*;;
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] result_unit;
    logic              last_of_text;

    modport source (output valid, output result_unit, output last_of_text, input ready);
    modport sink   (input valid, input result_unit, input last_of_text, output ready);
endinterface

`default_nettype wire

FILE: sv/k2h_conv.sv
// ============================================================================
// k2h_conv: input register and conversion logic
// Registers each accepted code unit, converts it against the held halfwidth
// kana and hands zero, one or two results to the result queue.
// ============================================================================
`default_nettype none

module k2h_conv import k2h_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    k2h_in_if.sink     i_src,
    input  wire logic  i_room,
    output t_push      o_push
);

    logic              r_in_valid;
    logic [UNIT_W-1:0] r_in_unit;
    logic              r_in_eot;
    logic              r_held_valid;
    logic [7:0]        r_held_lb;
    logic              n_held_valid;
    logic [7:0]        n_held_lb;
    logic              advance;
    logic              merged;
    t_push             push;

    // The registered unit moves on once the queue can take two results.
    assign advance     = r_in_valid && i_room;
    assign i_src.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_src.ready) begin
            r_in_valid <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_in_unit <= i_src.code_unit;
            r_in_eot  <= i_src.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_lb    <= 8'h00;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_lb    <= n_held_lb;
        end
    end

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_lb    = r_held_lb;
        merged       = 1'b0;
        push         = '0;
        if (advance) begin
            n_held_valid = 1'b0;
            n_held_lb    = 8'h00;
            if (r_held_valid) begin
                push.count = 2'd1;
                if (r_in_unit == MARK_VOICED) begin
                    push.res0.unit = voiced_of(r_held_lb);
                    push.res0.last = r_in_eot;
                    merged         = 1'b1;
                end else if ((r_in_unit == MARK_SEMI) && is_ha_row(r_held_lb)) begin
                    push.res0.unit = semi_of(r_held_lb);
                    push.res0.last = r_in_eot;
                    merged         = 1'b1;
                end else begin
                    // No mark follows, so the held kana goes out on its own.
                    push.res0.unit = convert_single({HALF_HI, r_held_lb});
                    push.res0.last = 1'b0;
                end
            end
            if (!merged) begin
                if (is_candidate(r_in_unit) && !r_in_eot) begin
                    n_held_valid = 1'b1;
                    n_held_lb    = r_in_unit[7:0];
                end else if (push.count == 2'd0) begin
                    push.count     = 2'd1;
                    push.res0.unit = convert_single(r_in_unit);
                    push.res0.last = r_in_eot;
                end else begin
                    push.count     = 2'd2;
                    push.res1.unit = convert_single(r_in_unit);
                    push.res1.last = r_in_eot;
                end
            end
        end
    end

    assign o_push = push;

endmodule

`default_nettype wire

FILE: sv/k2h_outq.sv
// ============================================================================
// k2h_outq: result queue
// Small register queue that takes up to two results per cycle and presents
// one result per cycle on the output channel while the receiver is ready.
// ============================================================================
`default_nettype none

module k2h_outq import k2h_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    k2h_out_if.source  o_res
);

    t_result              r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_wr_ptr;
    logic [Q_PTR_W-1:0]   n_rd_ptr;
    logic [Q_CNT_W-1:0]   n_count;
    logic [Q_PTR_W-1:0]   wr_next;
    logic                 pop;

    assign pop     = o_res.valid && o_res.ready;
    assign wr_next = r_wr_ptr + Q_PTR_W'(1);
    assign o_room  = r_count <= Q_CNT_W'(Q_DEPTH - 2);

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {{(Q_PTR_W-1){1'b0}}, pop};
        n_count  = r_count + {{(Q_CNT_W-2){1'b0}}, i_push.count}
                           - {{(Q_CNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    assign o_res.valid        = r_count != '0;
    assign o_res.result_unit  = r_mem[r_rd_ptr].unit;
    assign o_res.last_of_text = r_mem[r_rd_ptr].last;

endmodule

`default_nettype wire

FILE: sv/katakana_to_hiragana_stream.sv
// ============================================================================
// katakana_to_hiragana_stream: katakana to hiragana stream converter
// Converts a UTF-16 code unit stream, merging halfwidth kana with their
// voicing marks, and emits the hiragana code units.
// ============================================================================
// The source presents one UTF-16 code unit per transfer on i_src, with
// end_of_text set on the final unit of a string. Converted units leave on
// o_res, with last_of_text set on the final result of the string.
// Each transfer is captured in an input register; once the queue has room for
// two, the conversion logic compares it with the held halfwidth kana and writes
// zero, one or two results into a four-entry result queue, which drives o_res.
// The unit that completes a result passes through the input register and the
// result queue before the result is offered. A halfwidth kana that can take
// a voicing mark is held until the next unit arrives, or is sent at once
// when it ends the string. Throughput is one code unit per cycle while the
// queue has room. The output side moves one result per cycle, so a unit that
// flushes a held kana ahead of itself makes two results to send; the queue
// absorbs this while it has room for two. When the receiver stalls, the queue
// fills, the input register holds its unit and i_src.ready drops; nothing is
// lost or repeated. Reset clears the input register, the held kana and the
// queue; i_src.ready is high right after reset.
// ============================================================================
`default_nettype none

module katakana_to_hiragana_stream import k2h_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    k2h_in_if.sink     i_src,
    k2h_out_if.source  o_res
);

    // Results of one processed unit, handed from the converter to the queue.
    t_push push;
    // The queue can take a full pair of results this cycle.
    logic  room;

    k2h_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_room  (room),
        .o_push  (push)
    );

    k2h_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

FILE: sv/k2h_checker.sv
// ============================================================================
// k2h_checker: port-level checks
// Watches the stream ports of the converter over time.
// ============================================================================
`default_nettype none

module k2h_checker import k2h_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [UNIT_W-1:0] i_out_unit,
    input wire logic              i_out_last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_unit) && $stable(i_out_last))
        else $error("result payload changed while stalled");

    // Reset empties the result queue.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // Reset leaves the input register free to take a unit.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

endmodule

bind katakana_to_hiragana_stream k2h_checker u_k2h_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_src.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_unit  (o_res.result_unit),
    .i_out_last  (o_res.last_of_text)
);

`default_nettype wire
